/* rtl/dntp_pkg.sv */
// Shared types and constants for the decimal number text parser.
`default_nettype none

package dntp_pkg;

   // Widths of the result fields and of the digit counters
   localparam int unsigned MANT_W  = 63;
   localparam int unsigned EXP_W   = 16;
   localparam int unsigned COUNT_W = 14;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 14'h3FFF;

   // Character codes the scanner recognizes
   localparam logic [7:0] CH_POINT = 8'h2E;  // '.'
   localparam logic [7:0] CH_UPPER_E = 8'h45; // 'E'
   localparam logic [7:0] CH_LOWER_E = 8'h65; // 'e'
   localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

   // Item kinds
   localparam logic FUNC_CHAR = 1'b0;
   localparam logic FUNC_EOL  = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] ch;
   } req_word_type;

   typedef struct packed {
      logic                     negative;
      logic [MANT_W-1:0]        mantissa;
      logic signed [EXP_W-1:0]  decimal_exponent;
      logic                     overflow;
   } rsp_word_type;

   typedef enum logic [7:0] {
      ST_START    = 8'b0000_0001,
      ST_SIGN     = 8'b0000_0010,
      ST_INT      = 8'b0000_0100,
      ST_POINT    = 8'b0000_1000,
      ST_FRAC     = 8'b0001_0000,
      ST_EXP_MARK = 8'b0010_0000,
      ST_EXP_SIGN = 8'b0100_0000,
      ST_EXP_DIG  = 8'b1000_0000
   } scan_state_type;

endpackage

`default_nettype wire

/* rtl/decimal_number_text_parser.sv */
// Top level of the decimal number text parser: character scanner with one result per line.
//
// Usage:
//   req_*  : one word per character (func = 0, ch = byte) or an end-of-line word
//            (func = 1, ch ignored). The scanner takes an optional sign, integer
//            digits, a point with fraction digits and an exponent introduced by
//            E or e; characters that do not fit the current scan state are ignored.
//   rsp_*  : one word per end-of-line word: sign, saturated decimal mantissa,
//            power of ten (signed exponent minus fraction digit count) and an
//            overflow flag. All scan state then returns to line start.
//   Path:    an end-of-line word goes through the input register, then the result
//            register, which drives rsp_*.
//   Throughput: one word per cycle while no end-of-line word waits on a held result.
//            Each character costs one pass through a shift-and-add multiply by ten and a saturation check.
//   Stall: while a result waits on rsp_ready the input register keeps taking
//            character words; only an end-of-line word behind a held result
//            waits, and req_ready drops once that word fills the input register.
//   Reset: synchronous, active high; clears both valid flags and all scan state,
//            so the first line after reset starts clean.
`default_nettype none

module decimal_number_text_parser #(
   parameter int unsigned MANTISSA_BITS = 63
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  dntp_pkg::req_word_type  req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output dntp_pkg::rsp_word_type  rsp_data
);

   localparam int unsigned MB  = MANTISSA_BITS;
   localparam int unsigned MW  = dntp_pkg::MANT_W;
   localparam int unsigned EW  = dntp_pkg::EXP_W;
   localparam int unsigned CW  = dntp_pkg::COUNT_W;
   localparam int unsigned MPW = MB + 4;   // room for value * 10 + 9
   localparam int unsigned XPW = CW + 4;

   // Input register
   logic                   in_valid_ff;
   dntp_pkg::req_word_type in_data_ff;

   // Scan state
   dntp_pkg::scan_state_type state_ff, state_in;
   logic [MB-1:0] digit_ff, digit_in;
   logic [CW-1:0] frac_ff, frac_in;
   logic [CW-1:0] exp_ff, exp_in;
   logic          exp_neg_ff, exp_neg_in;
   logic          val_neg_ff, val_neg_in;
   logic          sat_ff, sat_in;

   // Result register
   logic                   rsp_valid_ff;
   dntp_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic out_free;
   logic proc;
   logic is_eol;

   // Character classes
   logic [7:0] ch;
   logic       is_dig, is_e, is_sign, is_minus, is_point;
   logic [3:0] dig_val;

   logic mant_step, frac_step, exp_step;
   logic [MPW-1:0] mant_prod;
   logic [XPW-1:0] exp_prod;

   logic signed [EW-1:0] exp_signed;
   logic signed [EW-1:0] pow_ten;

   // Handshake: a character word never needs the result slot
   assign is_eol    = (in_data_ff.func == dntp_pkg::FUNC_EOL);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign proc      = in_valid_ff && (!is_eol || out_free);
   assign req_ready = !in_valid_ff || proc;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      ch       = in_data_ff.ch;
      is_dig   = (ch >= dntp_pkg::CH_ZERO) && (ch <= dntp_pkg::CH_NINE);
      is_e     = (ch == dntp_pkg::CH_UPPER_E) || (ch == dntp_pkg::CH_LOWER_E);
      is_minus = (ch == dntp_pkg::CH_MINUS);
      is_sign  = (ch == dntp_pkg::CH_PLUS) || is_minus;
      is_point = (ch == dntp_pkg::CH_POINT);
      dig_val  = ch[3:0];   // low nibble of an ASCII digit is its value
   end

   // Multiply by ten as shift-and-add, one three-term add per path
   assign mant_prod = (MPW'(digit_ff) << 3) + (MPW'(digit_ff) << 1) + MPW'(dig_val);
   assign exp_prod  = (XPW'(exp_ff) << 3) + (XPW'(exp_ff) << 1) + XPW'(dig_val);

   // Result fields from the state left by earlier characters
   always_comb begin
      exp_signed = exp_neg_ff ? -EW'(exp_ff) : EW'(exp_ff);
      pow_ten    = exp_signed - EW'(frac_ff);
      rsp_data_in.negative         = val_neg_ff;
      rsp_data_in.mantissa         = MW'(digit_ff);
      rsp_data_in.decimal_exponent = pow_ten;
      rsp_data_in.overflow         = sat_ff;
   end

   // Scanner next state
   always_comb begin
      state_in   = state_ff;
      digit_in   = digit_ff;
      frac_in    = frac_ff;
      exp_in     = exp_ff;
      exp_neg_in = exp_neg_ff;
      val_neg_in = val_neg_ff;
      sat_in     = sat_ff;
      mant_step  = 1'b0;
      frac_step  = 1'b0;
      exp_step   = 1'b0;

      unique case (state_ff)
         dntp_pkg::ST_START, dntp_pkg::ST_SIGN: begin
            if (is_point) begin
               state_in = dntp_pkg::ST_POINT;
            end else if (state_ff == dntp_pkg::ST_START && is_sign) begin
               state_in   = dntp_pkg::ST_SIGN;
               val_neg_in = is_minus;
            end else if (is_dig) begin
               state_in  = dntp_pkg::ST_INT;
               mant_step = 1'b1;
            end
         end
         dntp_pkg::ST_INT: begin
            if (is_point) begin
               state_in = dntp_pkg::ST_FRAC;
            end else if (is_e) begin
               state_in = dntp_pkg::ST_EXP_MARK;
            end else if (is_dig) begin
               mant_step = 1'b1;
            end
         end
         dntp_pkg::ST_POINT: begin
            if (is_dig) begin
               state_in  = dntp_pkg::ST_FRAC;
               mant_step = 1'b1;
               frac_step = 1'b1;
            end
         end
         dntp_pkg::ST_FRAC: begin
            if (is_e) begin
               state_in = dntp_pkg::ST_EXP_MARK;
            end else if (is_dig) begin
               mant_step = 1'b1;
               frac_step = 1'b1;
            end
         end
         dntp_pkg::ST_EXP_MARK: begin
            if (is_sign) begin
               state_in   = dntp_pkg::ST_EXP_SIGN;
               exp_neg_in = is_minus;
            end else if (is_dig) begin
               state_in = dntp_pkg::ST_EXP_DIG;
               exp_step = 1'b1;
            end
         end
         dntp_pkg::ST_EXP_SIGN, dntp_pkg::ST_EXP_DIG: begin
            if (is_dig) begin
               state_in = dntp_pkg::ST_EXP_DIG;
               exp_step = 1'b1;
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase

      // Saturate the mantissa when value * 10 + digit spills past MB bits
      if (mant_step) begin
         if (mant_prod[MPW-1:MB] != '0) begin
            digit_in = '1;
            sat_in   = 1'b1;
         end else begin
            digit_in = mant_prod[MB-1:0];
         end
      end

      if (frac_step) begin
         if (frac_ff == dntp_pkg::COUNT_MAX) begin
            sat_in = 1'b1;
         end else begin
            frac_in = frac_ff + CW'(1);
         end
      end

      if (exp_step) begin
         if (exp_prod > XPW'(dntp_pkg::COUNT_MAX)) begin
            exp_in = dntp_pkg::COUNT_MAX;
            sat_in = 1'b1;
         end else begin
            exp_in = exp_prod[CW-1:0];
         end
      end

      // End of line: drop everything back to line start
      if (is_eol) begin
         state_in   = dntp_pkg::ST_START;
         digit_in   = '0;
         frac_in    = '0;
         exp_in     = '0;
         exp_neg_in = 1'b0;
         val_neg_in = 1'b0;
         sat_in     = 1'b0;
      end
   end

   // Input register: hold a word until the scanner takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // Scan state: advance on every processed word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dntp_pkg::ST_START;
         digit_ff   <= '0;
         frac_ff    <= '0;
         exp_ff     <= '0;
         exp_neg_ff <= 1'b0;
         val_neg_ff <= 1'b0;
         sat_ff     <= 1'b0;
      end else if (proc) begin
         state_ff   <= state_in;
         digit_ff   <= digit_in;
         frac_ff    <= frac_in;
         exp_ff     <= exp_in;
         exp_neg_ff <= exp_neg_in;
         val_neg_ff <= val_neg_in;
         sat_ff     <= sat_in;
      end
   end

   // Result register: load on end of line, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc && is_eol) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (proc && is_eol) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // An end-of-line word leaves a result and a clean scanner behind
   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      (proc && is_eol) |=> (rsp_valid_ff && state_ff == dntp_pkg::ST_START &&
                            digit_ff == '0 && !sat_ff))
      else $error("end of line did not clear the scanner");

   // Overflow is sticky within a line
   a_sat_sticky: assert property (@(posedge clock) disable iff (reset)
      (sat_ff && !(proc && is_eol)) |=> sat_ff)
      else $error("overflow flag dropped inside a line");

   // No mantissa digits before the first digit state
   a_digit_state: assert property (@(posedge clock) disable iff (reset)
      (digit_ff != '0) |-> !(state_ff == dntp_pkg::ST_START ||
                             state_ff == dntp_pkg::ST_SIGN ||
                             state_ff == dntp_pkg::ST_POINT))
      else $error("mantissa digits in a state that holds none");

   // Fraction digits only exist once the fraction has started
   a_frac_state: assert property (@(posedge clock) disable iff (reset)
      (frac_ff != '0) |-> !(state_ff == dntp_pkg::ST_START ||
                            state_ff == dntp_pkg::ST_SIGN ||
                            state_ff == dntp_pkg::ST_INT ||
                            state_ff == dntp_pkg::ST_POINT))
      else $error("fraction count set before any fraction digit");

   // A held result never gets overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !(proc && is_eol))
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire
